// ===== src/skf_pkg.sv =====
// Shared types, constants and the control store of the scalar Kalman filter.
package skf_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = FRAC_BITS + 1;
    localparam int REM_W     = DATA_W + 2;
    localparam int MA_W      = DATA_W + 2;
    localparam int MB_W      = GAIN_W + 1;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int CNT_W     = $clog2(FRAC_BITS + 1);
    localparam int STEP_W    = 3;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] COV_ONE  = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] U32_MAX  = {DATA_W{1'b1}};

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DEN,
        OP_DIV,
        OP_GAIN,
        OP_MULC,
        OP_EST,
        OP_MULP,
        OP_FIN
    } op_t;

    // Sequencing conditions
    typedef enum logic [1:0] {
        COND_NONE,
        COND_IN_VALID,
        COND_OUT_FREE,
        COND_LOOP
    } cond_t;

    typedef struct packed {
        op_t                op;
        cond_t              cond;
        logic [STEP_W-1:0]  target;
    } ucode_t;

    // Control toward the datapath
    typedef struct packed {
        op_t  op;
        logic en;
        logic wait_in;
    } ctrl_t;

    // Status from the datapath
    typedef struct packed {
        logic cnt_nz;
    } dp_status_t;

    // Step addresses of the program
    localparam logic [STEP_W-1:0] STEP_LOAD = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DEN  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DIV  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_GAIN = 3'd3;
    localparam logic [STEP_W-1:0] STEP_MULC = 3'd4;
    localparam logic [STEP_W-1:0] STEP_EST  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_MULP = 3'd6;
    localparam logic [STEP_W-1:0] STEP_FIN  = 3'd7;

    // Control store: one word per step
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{op: OP_NOP, cond: COND_NONE, target: STEP_LOAD};
        case (step)
            STEP_LOAD: w = '{op: OP_LOAD, cond: COND_IN_VALID, target: STEP_DEN};
            STEP_DEN:  w = '{op: OP_DEN,  cond: COND_NONE,     target: STEP_DIV};
            STEP_DIV:  w = '{op: OP_DIV,  cond: COND_LOOP,     target: STEP_DIV};
            STEP_GAIN: w = '{op: OP_GAIN, cond: COND_NONE,     target: STEP_MULC};
            STEP_MULC: w = '{op: OP_MULC, cond: COND_NONE,     target: STEP_EST};
            STEP_EST:  w = '{op: OP_EST,  cond: COND_NONE,     target: STEP_MULP};
            STEP_MULP: w = '{op: OP_MULP, cond: COND_NONE,     target: STEP_FIN};
            STEP_FIN:  w = '{op: OP_FIN,  cond: COND_OUT_FREE, target: STEP_LOAD};
            default:   w = '{op: OP_NOP,  cond: COND_NONE,     target: STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

// ===== src/skf_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jumps.
module skf_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_free,
    input  skf_pkg::dp_status_t status,
    output skf_pkg::ctrl_t      ctrl
);
    import skf_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            word;
    logic              en;

    assign word = ucode_rom(step_reg);

    // Step enable and next address
    always_comb
    begin
        en        = 1'b1;
        step_next = step_reg + STEP_W'(1);
        case (word.cond)
            COND_IN_VALID:
            begin
                en        = in_valid;
                step_next = in_valid ? word.target : step_reg;
            end
            COND_OUT_FREE:
            begin
                en        = out_free;
                step_next = out_free ? word.target : step_reg;
            end
            COND_LOOP:
            begin
                step_next = status.cnt_nz ? word.target : step_reg + STEP_W'(1);
            end
            default:
            begin
                step_next = step_reg + STEP_W'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_LOAD;
        else
            step_reg <= step_next;
    end

    assign ctrl.op      = word.op;
    assign ctrl.en      = en;
    assign ctrl.wait_in = (word.cond == COND_IN_VALID);

`ifndef SYNTH
    // A divide loop always leaves toward the gain step
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_DIV && !status.cnt_nz) |=> step_reg == STEP_GAIN)
        else $error("divide loop did not exit to gain step");
    // A stalled finish holds its step
    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_FIN && !out_free) |=> step_reg == STEP_FIN)
        else $error("finish step left while output busy");
    // Waiting for input holds the step
    a_wait_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_LOAD && !in_valid) |=> step_reg == STEP_LOAD)
        else $error("load step left without a request");
`endif
endmodule

// ===== src/skf_dp.sv =====
// Filter datapath: state, restoring divider, shared multiplier, saturation.
module skf_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  skf_pkg::ctrl_t                ctrl,
    input  logic [skf_pkg::DATA_W-1:0]    measurement,
    input  logic [skf_pkg::DATA_W-1:0]    q,
    input  logic [skf_pkg::DATA_W-1:0]    r,
    input  logic                          reload,
    input  logic [skf_pkg::DATA_W-1:0]    init_load,
    output skf_pkg::dp_status_t           status,
    output logic signed [skf_pkg::DATA_W-1:0] estimate,
    output logic [skf_pkg::GAIN_W-1:0]    gain
);
    import skf_pkg::*;

    // State and work registers
    logic signed [DATA_W-1:0] est_reg, est_next;
    logic [DATA_W-1:0]        cov_reg, cov_next;
    logic signed [DATA_W-1:0] meas_reg;
    logic [DATA_W-1:0]        p1_reg;
    logic [DATA_W:0]          den_reg;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [GAIN_W-1:0]        quo_reg, quo_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic signed [DATA_W:0]   diff_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [DATA_W-1:0] out_est_reg;
    logic [GAIN_W-1:0]        out_gain_reg;

    logic                     do_step;
    logic [DATA_W:0]          p1_sum;
    logic [DATA_W-1:0]        p1_next;
    logic                     rem_ge;
    logic [REM_W-1:0]         rem_sub;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic [GAIN_W-1:0]        gain_cmp;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [MA_W-1:0]   est_sum;
    logic [PROD_W-1:0]        cov_sh;

    assign do_step = ctrl.en;

    // Predicted covariance, saturated
    assign p1_sum  = {1'b0, cov_reg} + {1'b0, q};
    assign p1_next = p1_sum[DATA_W] ? U32_MAX : p1_sum[DATA_W-1:0];

    // One restoring divide step
    assign rem_ge  = rem_reg >= REM_W'(den_reg);
    assign rem_sub = rem_ge ? rem_reg - REM_W'(den_reg) : rem_reg;
    assign rem_next = {rem_sub[REM_W-2:0], 1'b0};
    assign quo_next = {quo_reg[GAIN_W-2:0], rem_ge};

    // Quotient clamp: covers the zero denominator too
    assign gain_cmp  = (quo_reg > GAIN_ONE) ? GAIN_ONE : quo_reg;
    assign gain_next = gain_cmp;

    // Shared multiplier operands
    always_comb
    begin
        if (ctrl.op == OP_MULP)
        begin
            mul_a = $signed({2'b00, p1_reg});
            mul_b = $signed({1'b0, GAIN_ONE - gain_reg});
        end
        else
        begin
            mul_a = MA_W'(diff_reg);
            mul_b = $signed({1'b0, gain_reg});
        end
    end
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Estimate update, floor shift then saturation
    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign est_sum = MA_W'(est_reg) + prod_sh[MA_W-1:0];
    always_comb
    begin
        if (est_sum[MA_W-1] && !(&est_sum[MA_W-2:DATA_W-1]))
            est_next = {1'b1, {(DATA_W-1){1'b0}}};
        else if (!est_sum[MA_W-1] && (|est_sum[MA_W-2:DATA_W-1]))
            est_next = {1'b0, {(DATA_W-1){1'b1}}};
        else
            est_next = est_sum[DATA_W-1:0];
    end

    // Covariance update, saturated
    assign cov_sh   = $unsigned(prod_reg) >> FRAC_BITS;
    assign cov_next = (|cov_sh[PROD_W-1:DATA_W]) ? U32_MAX : cov_sh[DATA_W-1:0];

    // Filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= '0;
            cov_reg <= COV_ONE;
            cnt_reg <= '0;
        end
        else if (reload)
        begin
            est_reg <= init_load;
            cov_reg <= COV_ONE;
        end
        else if (do_step)
        begin
            case (ctrl.op)
                OP_DEN:  cnt_reg <= CNT_W'(FRAC_BITS);
                OP_DIV:  cnt_reg <= cnt_reg - CNT_W'(1);
                OP_EST:  est_reg <= est_next;
                OP_FIN:  cov_reg <= cov_next;
                default: ;
            endcase
        end
    end

    // Work and output payload registers
    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            case (ctrl.op)
                OP_LOAD:
                begin
                    meas_reg <= measurement;
                    p1_reg   <= p1_next;
                end
                OP_DEN:
                begin
                    den_reg  <= {1'b0, p1_reg} + {1'b0, r};
                    rem_reg  <= REM_W'(p1_reg);
                    quo_reg  <= '0;
                    diff_reg <= (DATA_W+1)'(meas_reg) - (DATA_W+1)'(est_reg);
                end
                OP_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                end
                OP_GAIN: gain_reg <= gain_next;
                OP_MULC: prod_reg <= prod_next;
                OP_MULP: prod_reg <= prod_next;
                OP_FIN:
                begin
                    out_est_reg  <= est_reg;
                    out_gain_reg <= gain_reg;
                end
                default: ;
            endcase
        end
    end

    assign status.cnt_nz = (cnt_reg != '0);
    assign estimate      = out_est_reg;
    assign gain          = out_gain_reg;

`ifndef SYNTH
    // Reload puts the state back to its start point
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        reload |=> (cov_reg == COV_ONE && est_reg == $past(init_load)))
        else $error("state not reloaded after register write");
    // The gain never exceeds one
    a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
        (do_step && ctrl.op == OP_GAIN) |=> gain_reg <= GAIN_ONE)
        else $error("gain above one");
    // Divide setup loads the full iteration count
    a_cnt_load: assert property (@(posedge clk) disable iff (!rst_n)
        (do_step && !reload && ctrl.op == OP_DEN) |=> cnt_reg == CNT_W'(FRAC_BITS))
        else $error("divide count not loaded");
`endif
endmodule

// ===== src/scalar_kalman_filter.sv =====
// Scalar Kalman filter: register port, request handshake and output stage.
//
// Each accepted measurement (signed Q16.16) runs through a short microcode
// program and yields one request with the new estimate and the gain used.
// An item passes through these steps: the load step that accepts it,
// one divide setup step, FRAC_BITS + 1 restoring divide steps for the gain,
// one gain clamp step, two multiply steps on one shared multiplier and their
// two update steps. A new measurement is taken in the cycle after the result
// is registered; a result left waiting on the output holds the filter in its
// final step. Writing the q, r or initial estimate register reloads the
// estimate from initial_estimate and the covariance with 1.0.
module scalar_kalman_filter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [skf_pkg::DATA_W-1:0]  measurement,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [skf_pkg::DATA_W-1:0]  estimate,
    output logic [skf_pkg::GAIN_W-1:0]         gain
);
    import skf_pkg::*;

    localparam logic [1:0] REG_Q    = 2'd0;
    localparam logic [1:0] REG_R    = 2'd1;
    localparam logic [1:0] REG_INIT = 2'd2;

    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] r_reg;
    logic [DATA_W-1:0] init_reg;
    logic [DATA_W-1:0] init_load;
    logic [1:0]        reg_idx;
    logic              cfg_wr;
    logic              reload;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    ctrl_t             ctrl;
    dp_status_t        status;

    // Register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign reload  = cfg_wr && (reg_idx == REG_Q || reg_idx == REG_R || reg_idx == REG_INIT);
    assign init_load = (cfg_wr && reg_idx == REG_INIT) ? pwdata : init_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= 32'd655;
            r_reg    <= 32'd65536;
            init_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_Q:    q_reg    <= pwdata;
                REG_R:    r_reg    <= pwdata;
                REG_INIT: init_reg <= pwdata;
                default:  ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_idx)
            REG_Q:    prdata = q_reg;
            REG_R:    prdata = r_reg;
            REG_INIT: prdata = init_reg;
            default:  prdata = '0;
        endcase
    end

    // Output stage valid
    assign out_free = !out_valid_reg || out_ready;
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (ctrl.op == OP_FIN && ctrl.en)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;
    assign in_ready  = ctrl.wait_in;

    skf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .status   (status),
        .ctrl     (ctrl)
    );

    skf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .measurement (measurement),
        .q           (q_reg),
        .r           (r_reg),
        .reload      (reload),
        .init_load   (init_load),
        .status      (status),
        .estimate    (estimate),
        .gain        (gain)
    );

`ifndef SYNTH
    // An accepted request moves the program off the load step
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after a request");
    // A result appears only from the finish step
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !(ctrl.op == OP_FIN && ctrl.en)) |=> !out_valid)
        else $error("output valid without a finished item");
    // Input is never taken while the result stage is being filled
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_FIN) |-> !in_ready)
        else $error("input ready during finish step");
`endif
endmodule

// ===== dv/skf_checker.sv =====
// Checker for the scalar Kalman filter: predicts every result request and compares it.
module skf_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    input  logic [31:0]                         prdata,
    input  logic                                pready,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [skf_pkg::DATA_W-1:0]   measurement,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [skf_pkg::DATA_W-1:0]   estimate,
    input  logic [skf_pkg::GAIN_W-1:0]          gain,
    output int                                  mismatches,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import skf_pkg::*;

    // Register indexes (byte address / 4)
    localparam logic [1:0] IDX_PROCESS_NOISE     = 2'd0;
    localparam logic [1:0] IDX_MEASUREMENT_NOISE = 2'd1;
    localparam logic [1:0] IDX_INITIAL_ESTIMATE  = 2'd2;

    localparam logic [63:0]        UNIT      = 64'd1 << FRAC_BITS;
    localparam logic [63:0]        COV_LIMIT = 64'h0000_0000_FFFF_FFFF;
    localparam logic signed [63:0] EST_MAX   = 64'sd2147483647;
    localparam logic signed [63:0] EST_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] estimate;
        logic [GAIN_W-1:0]        gain;
    } kf_result_t;

    // Register mirror and filter state
    logic [31:0]        noise_q;
    logic [31:0]        noise_r;
    logic [31:0]        init_est;
    logic signed [63:0] est_cur;
    logic [63:0]        cov_cur;

    kf_result_t est_gain_q[$];

    // Estimate from the start value, covariance back to 1.0
    function automatic void restart_filter();
        est_cur = {{32{init_est[31]}}, init_est};
        cov_cur = UNIT;
    endfunction

    // One filter step: predict, gain, correct, shrink covariance
    function automatic kf_result_t filter_step(input logic signed [DATA_W-1:0] meas);
        logic [63:0]        p_pred;
        logic [63:0]        denom;
        logic [63:0]        k;
        logic [63:0]        p_next;
        logic signed [63:0] diff;
        logic signed [63:0] corr;
        logic signed [63:0] est_next;
        kf_result_t         res;
        p_pred = cov_cur + {32'd0, noise_q};
        if (p_pred > COV_LIMIT)
            p_pred = COV_LIMIT;
        denom = p_pred + {32'd0, noise_r};
        // zero denominator: take the gain as 1.0
        if (denom == 64'd0)
            k = UNIT;
        else
            k = (p_pred << FRAC_BITS) / denom;
        if (k > UNIT)
            k = UNIT;
        diff     = {{32{meas[DATA_W-1]}}, meas} - est_cur;
        corr     = ($signed(k) * diff) >>> FRAC_BITS;
        est_next = est_cur + corr;
        if (est_next > EST_MAX)
            est_next = EST_MAX;
        if (est_next < EST_MIN)
            est_next = EST_MIN;
        p_next = (p_pred * (UNIT - k)) >> FRAC_BITS;
        if (p_next > COV_LIMIT)
            p_next = COV_LIMIT;
        est_cur      = est_next;
        cov_cur      = p_next;
        res.estimate = est_next[DATA_W-1:0];
        res.gain     = k[GAIN_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%t mismatch on %s: expected 0x%0h, got 0x%0h",
                     $realtime, what, want, got);
    endtask

    // Watch the register port and both request channels
    always @(posedge clk or negedge rst_n)
    begin
        kf_result_t want;
        if (!rst_n)
        begin
            noise_q  = 32'd655;
            noise_r  = 32'h0001_0000;
            init_est = 32'd0;
            restart_filter();
            est_gain_q.delete();
        end
        else
        begin
            // register access phase
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        IDX_PROCESS_NOISE:
                        begin
                            noise_q = pwdata;
                            restart_filter();
                        end
                        IDX_MEASUREMENT_NOISE:
                        begin
                            noise_r = pwdata;
                            restart_filter();
                        end
                        IDX_INITIAL_ESTIMATE:
                        begin
                            init_est = pwdata;
                            restart_filter();
                        end
                        default: ;  // unmapped: state kept
                    endcase
                end
                else
                begin
                    case (paddr[3:2])
                        IDX_PROCESS_NOISE:
                            if (prdata !== noise_q)
                                flag_mismatch("process_noise read", 64'(noise_q),
                                              64'(prdata));
                        IDX_MEASUREMENT_NOISE:
                            if (prdata !== noise_r)
                                flag_mismatch("measurement_noise read", 64'(noise_r),
                                              64'(prdata));
                        IDX_INITIAL_ESTIMATE:
                            if (prdata !== init_est)
                                flag_mismatch("initial_estimate read", 64'(init_est),
                                              64'(prdata));
                        default: ;
                    endcase
                end
            end

            // result request against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (est_gain_q.size() == 0)
                    flag_mismatch("result with nothing pending", 64'd0, 64'(estimate));
                else
                begin
                    want = est_gain_q.pop_front();
                    if (estimate !== want.estimate)
                        flag_mismatch("estimate", 64'(want.estimate), 64'(estimate));
                    if (gain !== want.gain)
                        flag_mismatch("gain", 64'(want.gain), 64'(gain));
                end
            end

            // measurement request: predict its result
            if (in_valid && in_ready)
                est_gain_q.push_back(filter_step(measurement));
        end
        pending = est_gain_q.size();
    end

endmodule

// ===== dv/tb_scalar_kalman_filter.sv =====
// Testbench top for the scalar Kalman filter: stimulus, flow control and verdict.
module tb_scalar_kalman_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import skf_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int ITEMS_PER_PHASE = 660;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 40;

    // Register byte addresses
    localparam logic [3:0] ADDR_PROCESS_NOISE     = 4'h0;
    localparam logic [3:0] ADDR_MEASUREMENT_NOISE = 4'h4;
    localparam logic [3:0] ADDR_INITIAL_ESTIMATE  = 4'h8;
    localparam logic [3:0] ADDR_UNMAPPED          = 4'hC;

    localparam logic signed [DATA_W-1:0] MEAS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MEAS_MIN = 32'sh8000_0000;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [3:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [DATA_W-1:0]   measurement;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [DATA_W-1:0]   estimate;
    logic [GAIN_W-1:0]          gain;

    int mismatches;
    int pending;
    int tx_idle = 24;
    int rx_idle = 79;
    bit hold_go = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    scalar_kalman_filter uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .estimate    (estimate),
        .gain        (gain)
    );

    skf_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .estimate    (estimate),
        .gain        (gain),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // Register write: setup cycle, then access cycle
    task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Register read; the checker compares prdata
    task automatic reg_read(input logic [3:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_all_regs();
        reg_read(ADDR_PROCESS_NOISE);
        reg_read(ADDR_MEASUREMENT_NOISE);
        reg_read(ADDR_INITIAL_ESTIMATE);
    endtask

    // Offer one measurement request; each cycle before it may be idle
    task automatic offer_measurement(input logic signed [DATA_W-1:0] value);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        measurement <= value;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop offering and wait for every predicted result to come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_noise();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_start();
        case ($urandom_range(0, 5))
            0:       return MEAS_MIN;
            1:       return MEAS_MAX;
            2:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // A noisy constant level, plus extremes and wild samples
    function automatic logic signed [DATA_W-1:0] pick_measurement(
        input logic signed [DATA_W-1:0] level, input int unsigned spread);
        case ($urandom_range(0, 12))
            0:          return MEAS_MAX;
            1:          return MEAS_MIN;
            2:          return 32'sh0000_0000;
            3:          return -32'sd1;
            4, 5, 6:    return $urandom;
            default:    return level + $signed($urandom_range(0, 2 * spread))
                               - $signed(spread);
        endcase
    endfunction

    // New filter settings between runs of requests
    task automatic retune_filter();
        case ($urandom_range(0, 3))
            0: ;  // keep the filter running on its current state
            1: reg_write(ADDR_MEASUREMENT_NOISE, pick_noise());
            default:
            begin
                reg_write(ADDR_PROCESS_NOISE, pick_noise());
                reg_write(ADDR_MEASUREMENT_NOISE, pick_noise());
                reg_write(ADDR_INITIAL_ESTIMATE, pick_start());
            end
        endcase
        if ($urandom_range(0, 7) == 0)
            reg_write(ADDR_UNMAPPED, $urandom);
        if ($urandom_range(0, 3) == 0)
            read_all_regs();
    endtask

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // Run limit
    initial
    begin
        #(10_000_000);
        $display("Some tests failed");
        $finish;
    end

    // Stimulus
    initial
    begin
        int                       phase_items;
        int                       chunk;
        logic signed [DATA_W-1:0] level;
        int unsigned              spread;

        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        measurement <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings and extreme samples
        read_all_regs();
        offer_measurement(32'sh0000_0000);
        offer_measurement(MEAS_MAX);
        offer_measurement(MEAS_MIN);
        offer_measurement(-32'sd1);
        offer_measurement(32'sd1);
        drain_results();

        // no noise at all: gain 1.0, then a zero denominator
        reg_write(ADDR_PROCESS_NOISE, 32'h0000_0000);
        reg_write(ADDR_MEASUREMENT_NOISE, 32'h0000_0000);
        read_all_regs();
        offer_measurement(32'sh0001_0000);
        offer_measurement(MEAS_MAX);
        offer_measurement(MEAS_MIN);
        drain_results();

        // maximum noise, covariance saturates, start at the low limit
        reg_write(ADDR_PROCESS_NOISE, 32'hFFFF_FFFF);
        reg_write(ADDR_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
        reg_write(ADDR_INITIAL_ESTIMATE, MEAS_MIN);
        offer_measurement(MEAS_MAX);
        offer_measurement(MEAS_MAX);
        offer_measurement(MEAS_MIN);
        drain_results();

        // write to an unmapped address leaves the state alone
        reg_write(ADDR_UNMAPPED, 32'hA5A5_5A5A);
        offer_measurement(32'sh0000_0000);
        offer_measurement(MEAS_MAX);
        drain_results();

        // tiny r, start at the high limit, swing to the low one
        reg_write(ADDR_PROCESS_NOISE, 32'h0000_0000);
        reg_write(ADDR_MEASUREMENT_NOISE, 32'h0000_0001);
        reg_write(ADDR_INITIAL_ESTIMATE, MEAS_MAX);
        read_all_regs();
        offer_measurement(MEAS_MIN);
        offer_measurement(MEAS_MIN);
        drain_results();

        // huge q against no r
        reg_write(ADDR_PROCESS_NOISE, 32'hFFFF_FFFF);
        reg_write(ADDR_MEASUREMENT_NOISE, 32'h0000_0000);
        reg_write(ADDR_INITIAL_ESTIMATE, 32'h0000_0000);
        offer_measurement(32'sh1234_5678);
        offer_measurement(32'sh8765_4321);
        drain_results();

        // random part in three flow-control phases
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle     = (ph == 0) ? 24 : (ph == 1) ? 79 : 0;
            rx_idle     = (ph == 0) ? 79 : (ph == 1) ? 24 : 0;
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                retune_filter();
                level = pick_start();
                case ($urandom_range(0, 2))
                    0:       spread = 16;
                    1:       spread = 32'h0001_0000;
                    default: spread = 32'h0100_0000;
                endcase
                chunk = $urandom_range(10, 120);
                // long result hold-off while requests keep coming
                if (phase_items == 0 && ph != 1)
                    hold_go = 1'b1;
                repeat (chunk) offer_measurement(pick_measurement(level, spread));
                phase_items += chunk;
                drain_results();
            end
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
